// File: hw/rtl/tcrs_pkg.sv
// Shared types, constants and calendar table for the timed command release scheduler.
package tcrs_pkg;

	localparam int SLOTS_DEF = 8;
	localparam int YEARS_DEF = 21;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QLVL_W = $clog2(QDEPTH + 1);

	localparam int CFG_W = 32;
	localparam logic CFG_APID_MASK = 1'b0;
	localparam logic CFG_MIN_TIME = 1'b1;

	localparam logic [6:0] MASK_RESET = 7'd127;
	localparam logic [31:0] MIN_TIME_RESET = 32'd300;

	localparam logic [31:0] SECS_PER_DAY = 32'd86400;
	localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
	localparam logic [16:0] SECS_PER_MIN = 17'd60;
	localparam logic [15:0] DAYS_PER_YEAR = 16'd365;

	typedef enum logic [1:0] {
		K_TICK_BAD,
		K_TICK_OK,
		K_LOAD
	} kind_t;

	typedef enum logic [1:0] {
		ST_NONE,
		ST_RELEASED,
		ST_INVALID,
		ST_LOADED
	} status_t;

	typedef struct packed {
		kind_t kind;
		logic [31:0] mission_time;
		logic [2:0] entry_index;
		logic [31:0] release_at;
		logic [31:0] repeat_period;
		logic [2:0] target_app;
		logic load_enabled;
	} item_t;

	function automatic logic [8:0] days_before_month(input logic [3:0] month);
		logic [8:0] d;
		case (month)
			4'd2: d = 9'd31;
			4'd3: d = 9'd59;
			4'd4: d = 9'd90;
			4'd5: d = 9'd120;
			4'd6: d = 9'd151;
			4'd7: d = 9'd181;
			4'd8: d = 9'd212;
			4'd9: d = 9'd243;
			4'd10: d = 9'd273;
			4'd11: d = 9'd304;
			4'd12: d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

// File: hw/rtl/tcrs_front.sv
// Front end: takes requests, checks calendar fields and converts ticks to mission seconds.
module tcrs_front #(
	parameter int YEARS = tcrs_pkg::YEARS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic req_type,
	input  logic [6:0] year,
	input  logic [3:0] month,
	input  logic [4:0] day,
	input  logic [4:0] hour,
	input  logic [5:0] minute,
	input  logic [5:0] second,
	input  logic [2:0] entry_index,
	input  logic [31:0] release_at,
	input  logic [31:0] repeat_period,
	input  logic [2:0] target_app,
	input  logic load_enabled,
	input  logic [tcrs_pkg::QLVL_W-1:0] q_level,
	output logic push,
	output tcrs_pkg::item_t push_item
);
	import tcrs_pkg::*;

	logic accept;
	logic cal_ok;
	logic leap_bump;
	logic [7:0] year_p3;
	logic [15:0] days_d;
	logic [16:0] sod_d;
	logic [QLVL_W-1:0] occupancy;

	logic valid_s1;
	item_t item_s1;
	logic [15:0] days_s1;
	logic [16:0] sod_s1;
	item_t item_d2;

	logic valid_s2;
	item_t item_s2;

	always_comb begin
		occupancy = q_level + QLVL_W'(valid_s1) + QLVL_W'(valid_s2);
		busy = (32'(occupancy) >= 32'(QDEPTH));
		accept = start && !busy;

		cal_ok = (32'(year) < 32'(YEARS)) && (month inside {[4'd1:4'd12]}) &&
			(day != 5'd0) && (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59);
		leap_bump = (year[1:0] == 2'b00) && (month > 4'd2);
		year_p3 = 8'(year) + 8'd3;
		days_d = 16'(year) * DAYS_PER_YEAR + 16'(year_p3[7:2]) +
			16'(days_before_month(month)) + 16'(leap_bump) + 16'(day) - 16'd1;
		sod_d = 17'(hour) * SECS_PER_HOUR + 17'(minute) * SECS_PER_MIN + 17'(second);
	end

	always_comb begin
		item_d2 = item_s1;
		if (item_s1.kind == K_TICK_OK) begin
			item_d2.mission_time = 32'(days_s1) * SECS_PER_DAY + 32'(sod_s1);
		end else begin
			item_d2.mission_time = 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (req_type) begin
				item_s1.kind <= K_LOAD;
			end else if (cal_ok) begin
				item_s1.kind <= K_TICK_OK;
			end else begin
				item_s1.kind <= K_TICK_BAD;
			end
			item_s1.mission_time <= 32'd0;
			item_s1.entry_index <= entry_index;
			item_s1.release_at <= release_at;
			item_s1.repeat_period <= repeat_period;
			item_s1.target_app <= target_app;
			item_s1.load_enabled <= load_enabled;
			days_s1 <= days_d;
			sod_s1 <= sod_d;
		end
		if (valid_s1) begin
			item_s2 <= item_d2;
		end
	end

	assign push = valid_s2;
	assign push_item = item_s2;

endmodule

// File: hw/rtl/tcrs_queue.sv
// Short request queue between the front end and the scheduling back end.
module tcrs_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  tcrs_pkg::item_t push_item,
	input  logic pop,
	output logic head_valid,
	output tcrs_pkg::item_t head_item,
	output logic [tcrs_pkg::QLVL_W-1:0] level
);
	import tcrs_pkg::*;

	item_t store_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QLVL_W-1:0] count_q;
	logic do_pop;

	assign head_valid = (count_q != '0);
	assign head_item = store_q[rd_ptr_q];
	assign level = count_q;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QLVL_W'(push) - QLVL_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// File: hw/rtl/tcrs_back.sv
// Back end: schedule table, scan pointer, release decision and result registers.
module tcrs_back #(
	parameter int SLOTS = tcrs_pkg::SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [tcrs_pkg::CFG_W-1:0] cfg_data,
	input  logic head_valid,
	input  tcrs_pkg::item_t head_item,
	output logic pop,
	output logic done,
	output logic [1:0] status,
	output logic [2:0] released_slot,
	output logic [2:0] released_app,
	output logic [31:0] mission_time,
	output logic [3:0] loaded_entries,
	output logic table_full
);
	import tcrs_pkg::*;

	localparam int PTR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	typedef struct packed {
		logic [31:0] release_at;
		logic [31:0] period;
		logic [2:0] app;
	} slot_t;

	slot_t mem [SLOTS];
	slot_t rd_q;

	logic [SLOTS-1:0] valid_q;
	logic [SLOTS-1:0] enabled_q;
	logic [PTR_W-1:0] scan_q;
	logic [CNT_W-1:0] count_q;
	logic [6:0] mask_q;
	logic [31:0] min_time_q;

	logic done_q;
	status_t status_q;
	logic [2:0] slot_q;
	logic [2:0] app_q;
	logic [31:0] mtime_q;
	logic [3:0] loaded_q;
	logic full_q;

	logic is_load;
	logic is_tick;
	logic release_now;
	logic free_slot;
	logic [7:0] mask_ext;
	logic [PTR_W-1:0] load_addr;
	logic [PTR_W-1:0] scan_d;
	logic wr_en;
	logic [PTR_W-1:0] wr_addr;
	slot_t wr_data;
	logic [CNT_W-1:0] count_d;
	status_t status_d;

	always_comb begin
		mask_ext = {mask_q, 1'b0};
		load_addr = PTR_W'(head_item.entry_index);
		is_load = head_valid && (head_item.kind == K_LOAD) &&
			(32'(head_item.entry_index) < 32'(SLOTS));
		is_tick = head_valid && (head_item.kind == K_TICK_OK) &&
			(head_item.mission_time >= min_time_q);
		release_now = is_tick && valid_q[scan_q] && enabled_q[scan_q] &&
			mask_ext[rd_q.app] && (rd_q.release_at <= head_item.mission_time);
		free_slot = release_now && (rd_q.period == 32'd0);

		if (is_tick) begin
			scan_d = (scan_q == PTR_W'(SLOTS - 1)) ? '0 : scan_q + 1'b1;
		end else begin
			scan_d = scan_q;
		end

		wr_en = is_load || (release_now && !free_slot);
		if (is_load) begin
			wr_addr = load_addr;
			wr_data = '{release_at: head_item.release_at, period: head_item.repeat_period,
				app: head_item.target_app};
		end else begin
			wr_addr = scan_q;
			wr_data = '{release_at: rd_q.release_at + rd_q.period, period: rd_q.period,
				app: rd_q.app};
		end

		count_d = count_q;
		if (is_load && !valid_q[load_addr]) begin
			count_d = count_q + 1'b1;
		end else if (free_slot) begin
			count_d = count_q - 1'b1;
		end

		case (head_item.kind)
			K_LOAD: status_d = ST_LOADED;
			K_TICK_OK: status_d = !is_tick ? ST_INVALID :
				(release_now ? ST_RELEASED : ST_NONE);
			default: status_d = ST_INVALID;
		endcase
	end

	assign pop = head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			enabled_q <= '0;
			scan_q <= '0;
			count_q <= '0;
			mask_q <= MASK_RESET;
			min_time_q <= MIN_TIME_RESET;
			done_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_APID_MASK: mask_q <= cfg_data[6:0];
					CFG_MIN_TIME: min_time_q <= cfg_data[31:0];
					default: ;
				endcase
			end
			if (is_load) begin
				valid_q[load_addr] <= 1'b1;
				enabled_q[load_addr] <= head_item.load_enabled;
			end else if (free_slot) begin
				valid_q[scan_q] <= 1'b0;
				enabled_q[scan_q] <= 1'b0;
			end
			scan_q <= scan_d;
			count_q <= count_d;
			done_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (wr_en && (wr_addr == scan_d)) begin
			rd_q <= wr_data;
		end else begin
			rd_q <= mem[scan_d];
		end
	end

	always_ff @(posedge clk) begin
		if (head_valid) begin
			status_q <= status_d;
			slot_q <= release_now ? 3'(scan_q) : 3'd0;
			app_q <= release_now ? rd_q.app : 3'd0;
			mtime_q <= head_item.mission_time;
			loaded_q <= 4'(count_d);
			full_q <= (32'(count_d) == 32'(SLOTS));
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign released_slot = slot_q;
	assign released_app = app_q;
	assign mission_time = mtime_q;
	assign loaded_entries = loaded_q;
	assign table_full = full_q;

endmodule

// File: hw/rtl/timed_command_release_scheduler.sv
// Top level of the timed command release scheduler.
//
// Channel  | Handshake         | Signals
// request  | start / busy      | req_type, year .. second, entry_index .. load_enabled
// result   | done (one cycle)  | status, released_slot, released_app, mission_time,
//          |                   | loaded_entries, table_full
// config   | cfg_we            | cfg_index, cfg_data
//
// One request can be taken every clock cycle while busy is low; the back end retires one per cycle.
// The result strobe follows the request through two front stages for the calendar
// conversion, then the queue head and the result register.
// busy is raised only when the queue plus the two front stages hold a full queue's worth.
// The receiver cannot stall results, so the queue never holds more than one request.
// Reset clears the valid and enable flags, the count, the scan pointer and done, and loads the config defaults.
module timed_command_release_scheduler #(
	parameter int SLOTS = tcrs_pkg::SLOTS_DEF,
	parameter int YEARS = tcrs_pkg::YEARS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic req_type,
	input  logic [6:0] year,
	input  logic [3:0] month,
	input  logic [4:0] day,
	input  logic [4:0] hour,
	input  logic [5:0] minute,
	input  logic [5:0] second,
	input  logic [2:0] entry_index,
	input  logic [31:0] release_at,
	input  logic [31:0] repeat_period,
	input  logic [2:0] target_app,
	input  logic load_enabled,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [tcrs_pkg::CFG_W-1:0] cfg_data,
	output logic done,
	output logic [1:0] status,
	output logic [2:0] released_slot,
	output logic [2:0] released_app,
	output logic [31:0] mission_time,
	output logic [3:0] loaded_entries,
	output logic table_full
);
	import tcrs_pkg::*;

	logic push;
	item_t push_item;
	logic pop;
	logic head_valid;
	item_t head_item;
	logic [QLVL_W-1:0] q_level;

	tcrs_front #(
		.YEARS(YEARS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.year(year),
		.month(month),
		.day(day),
		.hour(hour),
		.minute(minute),
		.second(second),
		.entry_index(entry_index),
		.release_at(release_at),
		.repeat_period(repeat_period),
		.target_app(target_app),
		.load_enabled(load_enabled),
		.q_level(q_level),
		.push(push),
		.push_item(push_item)
	);

	tcrs_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.pop(pop),
		.head_valid(head_valid),
		.head_item(head_item),
		.level(q_level)
	);

	tcrs_back #(
		.SLOTS(SLOTS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.head_valid(head_valid),
		.head_item(head_item),
		.pop(pop),
		.done(done),
		.status(status),
		.released_slot(released_slot),
		.released_app(released_app),
		.mission_time(mission_time),
		.loaded_entries(loaded_entries),
		.table_full(table_full)
	);

endmodule
